### rtl/core/acp_pkg.sv
// Shared types, constants and AES byte functions for the AES-256 CBC block.
// No dependencies; used by acp_key_unit and aes256_cbc_pkcs7_cipher.
package acp_pkg;

  localparam int NUM_ROUNDS = 14;
  localparam int NUM_RKEYS  = NUM_ROUNDS + 1;
  localparam int BLK_BYTES  = 16;
  localparam int TDATA_W    = 136;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_UP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd6;

  // result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BAD_PAD = 2'd1;
  localparam logic [1:0] STS_PARTIAL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY,
    S_CRYPT,
    S_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic start;
  } key_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } key_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one forward round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] res;
    for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r+4*c] = SBOX[a[r+4*((c+r)%4)]];
    for (int c = 0; c < 4; c++) begin
      m[4*c+0] = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int i = 0; i < 16; i++)
      res[127-8*i -: 8] = (final_rnd ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    return res;
  endfunction

  // one inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns if mix
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] a [16];
    logic [7:0] t [16];
    logic [7:0] x2, x4, x8, y2, y4, y8, z2, z4, z8, w2, w4, w8;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) a[i] = s[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r+4*((c+r)%4)] = INV_SBOX[a[r+4*c]];
    for (int i = 0; i < 16; i++) t[i] = t[i] ^ rk[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      x2 = xtime(t[4*c]);   x4 = xtime(x2); x8 = xtime(x4);
      y2 = xtime(t[4*c+1]); y4 = xtime(y2); y8 = xtime(y4);
      z2 = xtime(t[4*c+2]); z4 = xtime(z2); z8 = xtime(z4);
      w2 = xtime(t[4*c+3]); w4 = xtime(w2); w8 = xtime(w4);
      // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
      a[4*c+0] = (x8^x4^x2) ^ (y8^y2^t[4*c+1]) ^ (z8^z4^t[4*c+2]) ^ (w8^t[4*c+3]);
      a[4*c+1] = (x8^t[4*c]) ^ (y8^y4^y2) ^ (z8^z2^t[4*c+2]) ^ (w8^w4^t[4*c+3]);
      a[4*c+2] = (x8^x4^t[4*c]) ^ (y8^t[4*c+1]) ^ (z8^z4^z2) ^ (w8^w2^t[4*c+3]);
      a[4*c+3] = (x8^x2^t[4*c]) ^ (y8^y4^t[4*c+1]) ^ (z8^t[4*c+2]) ^ (w8^w4^w2);
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = mix ? a[i] : t[i];
    return res;
  endfunction

endpackage

### rtl/core/acp_key_unit.sv
// AES-256 key expansion: one round key per cycle into a 15-entry key store.
// Depends on acp_pkg (S-box, control and status structs).
module acp_key_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [255:0]        key_i,
  input  acp_pkg::key_ctl_t   ctl_i,
  input  logic [3:0]          rd_idx_i,
  output logic [127:0]        rk_o,
  output acp_pkg::key_sts_t   sts_o
);
  import acp_pkg::*;

  logic [127:0] rk_r [NUM_RKEYS];
  logic [127:0] prev2_r, prev1_r;
  logic [3:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [127:0] new_rk;

  // next round key from the two before it
  function automatic logic [127:0] next_rk(input logic [127:0] p2, input logic [127:0] p1,
                                           input logic [3:0] idx);
    logic [31:0] t, w0, w1, w2, w3;
    logic [7:0]  rc;
    rc = 8'h01 << (idx[3:1] - 3'd1);
    if (!idx[0]) begin
      t = {sub_byte(p1[23:16]) ^ rc, sub_byte(p1[15:8]), sub_byte(p1[7:0]),
           sub_byte(p1[31:24])};
    end else begin
      t = {sub_byte(p1[31:24]), sub_byte(p1[23:16]), sub_byte(p1[15:8]), sub_byte(p1[7:0])};
    end
    w0 = p2[127:96] ^ t;
    w1 = p2[95:64]  ^ w0;
    w2 = p2[63:32]  ^ w1;
    w3 = p2[31:0]   ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  assign new_rk = next_rk(prev2_r, prev1_r, step_r);

  // step sequencer
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl_i.start) begin
      step_nxt = 4'd2;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 4'd1;
      if (step_r == 4'(NUM_ROUNDS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // key store and the two-key window
  always_ff @(posedge clk) begin
    if (ctl_i.start) begin
      rk_r[0] <= key_i[255:128];
      rk_r[1] <= key_i[127:0];
      prev2_r <= key_i[255:128];
      prev1_r <= key_i[127:0];
    end else if (busy_r) begin
      rk_r[step_r] <= new_rk;
      prev2_r      <= prev1_r;
      prev1_r      <= new_rk;
    end
  end

  assign rk_o       = rk_r[rd_idx_i];
  assign sts_o.busy = busy_r;
  assign sts_o.done = done_r;

endmodule

### rtl/core/aes256_cbc_pkcs7_cipher.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | tdata: block_upper, block_lower, valid_bytes; tlast
// out_    | out | out_tvalid/out_tready | tdata: result_upper, result_lower, result_bytes;
//         |     |                     | tlast: result_last; tuser: status
// cfg_    | in  | cfg_wr_en           | cfg_addr register index, cfg_wdata value
// Each item is accepted, makes 15 passes of the shared round unit (key add plus 14
// rounds) and finishes; a partial block when decrypting skips the passes. A full last
// block when encrypting adds a pad block. After a key write, the next item first waits
// for key expansion, one round key per cycle. Finishing waits while the output register
// is held by a stalled consumer. Reset is synchronous; the first item chains from IV.
module aes256_cbc_pkcs7_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [acp_pkg::TDATA_W-1:0]        in_tdata,   // block_upper, block_lower, valid_bytes
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [acp_pkg::TDATA_W-1:0]        out_tdata,  // result_upper, result_lower, result_bytes
  output logic                               out_tlast,
  output logic [1:0]                         out_tuser,  // status
  input  logic                               cfg_wr_en,
  input  logic [acp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [acp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import acp_pkg::*;

  // configuration registers
  logic [63:0] key0_r, key1_r, key2_r, key3_r, iv_up_r, iv_lo_r;
  logic        decrypt_r;
  logic        key_ok_r, key_ok_nxt;

  // item state
  ctl_state_t  state_r, state_nxt;
  logic [127:0] s_r, s_nxt, chain_r, chain_nxt, blk_r, blk_nxt;
  logic        last_r, last_nxt, pad2_r, pad2_nxt, part_r, part_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [3:0]  rnd_r, rnd_nxt;

  // output register
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [127:0] odata_r, odata_nxt;
  logic [4:0]  obytes_r, obytes_nxt;
  logic [1:0]  osts_r, osts_nxt;

  key_ctl_t    kctl;
  key_sts_t    ksts;
  logic [3:0]  kidx;
  logic [127:0] rk;

  // intermediate values
  logic [4:0]  in_vb;
  logic [127:0] in_blk, in_chain, padded, plain, zapped;
  logic [7:0]  pad;
  logic        pad_ok;

  acp_key_unit u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_i    ({key0_r, key1_r, key2_r, key3_r}),
    .ctl_i    (kctl),
    .rd_idx_i (kidx),
    .rk_o     (rk),
    .sts_o    (ksts)
  );

  assign kidx = decrypt_r ? (4'(NUM_ROUNDS) - rnd_r) : rnd_r;

  // input decode: clamp count, full middle blocks, PKCS#7 fill
  always_comb begin
    in_vb = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];
    if (!in_tlast) in_vb = 5'd16;
    in_blk   = {in_tdata[63:0], in_tdata[127:64]};
    in_chain = in_msg_r ? chain_r : {iv_up_r, iv_lo_r};
    for (int i = 0; i < BLK_BYTES; i++)
      padded[127-8*i -: 8] = (5'(i) >= in_vb) ? {3'd0, 5'd16 - in_vb} : in_blk[127-8*i -: 8];
  end

  // decrypt padding check
  always_comb begin
    plain  = s_r ^ chain_r;
    pad    = plain[7:0];
    pad_ok = (pad != 8'd0) && (pad <= 8'd16);
    zapped = plain;
    for (int i = 0; i < BLK_BYTES; i++) begin
      if ((9'(i) + {1'b0, pad}) >= 9'd16) begin
        zapped[127-8*i -: 8] = 8'd0;
        if (plain[127-8*i -: 8] != pad) pad_ok = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    chain_nxt  = chain_r;
    blk_nxt    = blk_r;
    last_nxt   = last_r;
    pad2_nxt   = pad2_r;
    part_nxt   = part_r;
    in_msg_nxt = in_msg_r;
    rnd_nxt    = rnd_r;
    key_ok_nxt = key_ok_r;
    kctl.start = 1'b0;
    ov_nxt     = ov_r && !out_tready;
    odata_nxt  = odata_r;
    obytes_nxt = obytes_r;
    olast_nxt  = olast_r;
    osts_nxt   = osts_r;
    in_tready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_tlast;
          chain_nxt = in_chain;
          blk_nxt   = in_blk;
          rnd_nxt   = 4'd0;
          s_nxt     = decrypt_r ? in_blk : (padded ^ in_chain);
          pad2_nxt  = !decrypt_r && in_tlast && (in_vb == 5'd16);
          part_nxt  = decrypt_r && (in_vb != 5'd16);
          if (decrypt_r && (in_vb != 5'd16)) begin
            state_nxt = S_FINISH;
          end else if (!key_ok_r) begin
            kctl.start = 1'b1;
            state_nxt  = S_KEY;
          end else begin
            state_nxt = S_CRYPT;
          end
        end
      end
      S_KEY: begin
        if (ksts.done) begin
          key_ok_nxt = 1'b1;
          state_nxt  = S_CRYPT;
        end
      end
      S_CRYPT: begin
        if (rnd_r == 4'd0) s_nxt = s_r ^ rk;
        else if (decrypt_r) s_nxt = dec_round(s_r, rk, rnd_r != 4'(NUM_ROUNDS));
        else s_nxt = enc_round(s_r, rk, rnd_r == 4'(NUM_ROUNDS));
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'(NUM_ROUNDS)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (part_r) begin
            odata_nxt  = 128'd0;
            obytes_nxt = 5'd0;
            olast_nxt  = last_r;
            osts_nxt   = STS_PARTIAL;
            in_msg_nxt = !last_r;
          end else if (!decrypt_r) begin
            odata_nxt  = s_r;
            obytes_nxt = 5'd16;
            olast_nxt  = last_r && !pad2_r;
            osts_nxt   = STS_OK;
            chain_nxt  = s_r;
            if (pad2_r) begin
              s_nxt     = {BLK_BYTES{8'h10}} ^ s_r;
              pad2_nxt  = 1'b0;
              rnd_nxt   = 4'd0;
              state_nxt = S_CRYPT;
            end else begin
              in_msg_nxt = !last_r;
            end
          end else begin
            chain_nxt  = blk_r;
            in_msg_nxt = !last_r;
            olast_nxt  = last_r;
            if (!last_r) begin
              odata_nxt  = plain;
              obytes_nxt = 5'd16;
              osts_nxt   = STS_OK;
            end else if (pad_ok) begin
              odata_nxt  = zapped;
              obytes_nxt = 5'd16 - pad[4:0];
              osts_nxt   = STS_OK;
            end else begin
              odata_nxt  = 128'd0;
              obytes_nxt = 5'd0;
              osts_nxt   = STS_BAD_PAD;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a key write invalidates the expanded schedule
    if (cfg_wr_en && (cfg_addr == CFG_KEY0 || cfg_addr == CFG_KEY1 ||
                      cfg_addr == CFG_KEY2 || cfg_addr == CFG_KEY3))
      key_ok_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_msg_r <= 1'b0;
      key_ok_r <= 1'b0;
      ov_r     <= 1'b0;
      rnd_r    <= 4'd0;
      pad2_r   <= 1'b0;
      part_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_msg_r <= in_msg_nxt;
      key_ok_r <= key_ok_nxt;
      ov_r     <= ov_nxt;
      rnd_r    <= rnd_nxt;
      pad2_r   <= pad2_nxt;
      part_r   <= part_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    chain_r  <= chain_nxt;
    blk_r    <= blk_nxt;
    last_r   <= last_nxt;
    odata_r  <= odata_nxt;
    obytes_r <= obytes_nxt;
    olast_r  <= olast_nxt;
    osts_r   <= osts_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r    <= 64'd0;
      key1_r    <= 64'd0;
      key2_r    <= 64'd0;
      key3_r    <= 64'd0;
      iv_up_r   <= 64'd0;
      iv_lo_r   <= 64'd0;
      decrypt_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_KEY0:    key0_r    <= cfg_wdata;
        CFG_KEY1:    key1_r    <= cfg_wdata;
        CFG_KEY2:    key2_r    <= cfg_wdata;
        CFG_KEY3:    key3_r    <= cfg_wdata;
        CFG_IV_UP:   iv_up_r   <= cfg_wdata;
        CFG_IV_LO:   iv_lo_r   <= cfg_wdata;
        CFG_DECRYPT: decrypt_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'd0, obytes_r, odata_r[63:0], odata_r[127:64]};
  assign out_tlast  = olast_r;
  assign out_tuser  = osts_r;

`ifndef SYNTHESIS
  // rounds only run on an expanded schedule
  a_key_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRYPT |-> key_ok_r && !ksts.busy)
    else $error("round unit ran without a valid key schedule");

  // round counter stays within the key store
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRYPT |-> rnd_r <= 4'(NUM_ROUNDS))
    else $error("round counter out of range");

  // a partial decrypt result is always empty
  a_partial_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && osts_r == STS_PARTIAL |-> obytes_r == 5'd0)
    else $error("partial block result carries bytes");
`endif

endmodule
